@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the core RTL
// Clocked, reset-gated concurrent forms of the usual property shapes.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/potts_pkg.sv @@
// ----------------------------------------------------------------------------
// potts_pkg
// Types and constants for the Potts Metropolis spin update core.
// ----------------------------------------------------------------------------
`default_nettype none

package potts_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int MAX_STATES_DEF = 16;

	// match counts run 0..4, five values per axis of the table
	localparam int MATCH_SPAN = 5;
	localparam int TABLE_ROW  = MATCH_SPAN * MATCH_SPAN;
	localparam logic [2:0]  MATCH_MAX = 3'd4;
	localparam logic [16:0] PROB_ONE  = 17'd65536;

	localparam logic [7:0] WIDTH_RST  = 8'd128;
	localparam logic [7:0] HEIGHT_RST = 8'd128;
	localparam logic [4:0] STATES_RST = 5'd2;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_STATES = 2'd2
	} potts_reg_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_STEP  = 2'd3
	} potts_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SITE,
		ST_NBR,
		ST_TABLE,
		ST_DECIDE,
		ST_DONE
	} potts_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  site_x;
		logic [6:0]  site_y;
		logic [3:0]  spin_value;
		logic [3:0]  other_spin;
		logic [2:0]  old_matches;
		logic [2:0]  new_matches;
		logic [3:0]  candidate_offset;
		logic [15:0] random_draw;
		logic [16:0] probability;
	} potts_in_t;

	typedef struct packed {
		logic [3:0] result_spin;
		logic       accepted;
		logic [2:0] old_match_count;
		logic [2:0] new_match_count;
		logic       status;
	} potts_out_t;

	typedef struct packed {
		logic [7:0] width;
		logic [7:0] height;
		logic [4:0] states;
	} potts_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/potts_ram.sv @@
// ----------------------------------------------------------------------------
// potts_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module potts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ rtl/core/potts_ctrl.sv @@
// ----------------------------------------------------------------------------
// potts_ctrl
// Sequencer and datapath: walks site, neighbors and table through the two
// single-port stores, one access per cycle, with old and new match counters.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module potts_ctrl import potts_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int MAX_STATES = MAX_STATES_DEF,
	localparam int LAT_AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int TBL_AW = $clog2(MAX_STATES * MAX_STATES * TABLE_ROW)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire potts_cfg_t        cfg,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire potts_in_t         req,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output potts_out_t             res,
	output logic                   lat_we,
	output logic      [LAT_AW-1:0] lat_addr,
	output logic      [3:0]        lat_wdata,
	input  wire logic [3:0]        lat_rdata,
	output logic                   tbl_we,
	output logic      [TBL_AW-1:0] tbl_addr,
	output logic      [16:0]       tbl_wdata,
	input  wire logic [16:0]       tbl_rdata
);

	potts_state_t state_q, state_d;
	potts_in_t    item_q;
	logic         bad_q;
	logic [3:0]   olds_q;
	logic [3:0]   res_spin_q;
	logic         acc_q;
	logic [2:0]   oc_q;
	logic [2:0]   nc_q;
	logic [1:0]   nbr_q;

	logic       cfg_ok, site_bad, arg_bad;
	logic       stale, take;
	logic [3:0] cand;
	logic [7:0] x8, y8, xm, xp, ym, yp, sel_x, sel_y;
	logic [3:0] t_old, t_new;
	logic [2:0] t_om, t_nm;

	// argument checks on the incoming item
	always_comb begin
		cfg_ok = (cfg.width >= 8'd2) && (32'(cfg.width) <= MAX_WIDTH) &&
			(cfg.height >= 8'd2) && (32'(cfg.height) <= MAX_HEIGHT) &&
			(cfg.states >= 5'd2) && (32'(cfg.states) <= MAX_STATES);
		site_bad = ({1'b0, req.site_x} >= cfg.width) || ({1'b0, req.site_y} >= cfg.height);
		case (potts_op_t'(req.op))
			OP_LOAD: arg_bad = ({1'b0, req.spin_value} >= cfg.states) ||
				({1'b0, req.other_spin} >= cfg.states) ||
				(req.old_matches > MATCH_MAX) || (req.new_matches > MATCH_MAX) ||
				(req.probability > PROB_ONE);
			OP_WRITE: arg_bad = site_bad || ({1'b0, req.spin_value} >= cfg.states);
			OP_READ:  arg_bad = site_bad;
			OP_STEP:  arg_bad = site_bad ||
				({1'b0, req.candidate_offset} >= (cfg.states - 5'd1));
			default:  arg_bad = 1'b1;
		endcase
		arg_bad = arg_bad || !cfg_ok;
	end

	// torus neighbor coordinates
	always_comb begin
		x8 = {1'b0, item_q.site_x};
		y8 = {1'b0, item_q.site_y};
		xm = (x8 == 8'd0) ? cfg.width - 8'd1 : x8 - 8'd1;
		ym = (y8 == 8'd0) ? cfg.height - 8'd1 : y8 - 8'd1;
		xp = (x8 + 8'd1 == cfg.width) ? 8'd0 : x8 + 8'd1;
		yp = (y8 + 8'd1 == cfg.height) ? 8'd0 : y8 + 8'd1;
		sel_x = x8;
		sel_y = y8;
		if (state_q == ST_SITE) begin
			sel_x = xm;
		end else if (state_q == ST_NBR) begin
			case (nbr_q)
				2'd0: sel_y = ym;
				2'd1: sel_x = xp;
				2'd2: sel_y = yp;
				default: ;
			endcase
		end
		lat_addr = LAT_AW'(32'(sel_y) * MAX_WIDTH + 32'(sel_x));
	end

	// candidate skips the current spin
	assign cand  = (item_q.candidate_offset < olds_q) ? item_q.candidate_offset :
		item_q.candidate_offset + 4'd1;
	assign stale = {1'b0, lat_rdata} >= cfg.states;
	assign take  = {1'b0, item_q.random_draw} <= tbl_rdata;

	always_comb begin
		if (state_q == ST_EXEC) begin
			t_old = item_q.spin_value;
			t_new = item_q.other_spin;
			t_om  = item_q.old_matches;
			t_nm  = item_q.new_matches;
		end else begin
			t_old = olds_q;
			t_new = cand;
			t_om  = oc_q;
			t_nm  = nc_q;
		end
		tbl_addr = TBL_AW'(32'(t_old) * (MAX_STATES * TABLE_ROW) + 32'(t_new) * TABLE_ROW +
			32'(t_om) * MATCH_SPAN + 32'(t_nm));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = (state_q != ST_IDLE);
		res_valid = 1'b0;
		lat_we    = 1'b0;
		tbl_we    = 1'b0;
		lat_wdata = item_q.spin_value;
		tbl_wdata = item_q.probability;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (bad_q) begin
					state_d = ST_DONE;
				end else begin
					case (potts_op_t'(item_q.op))
						OP_LOAD: begin
							tbl_we  = 1'b1;
							state_d = ST_DONE;
						end
						OP_WRITE: begin
							lat_we  = 1'b1;
							state_d = ST_DONE;
						end
						OP_READ, OP_STEP: state_d = ST_SITE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SITE: begin
				if (item_q.op == OP_READ || stale) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_NBR;
				end
			end
			ST_NBR: begin
				if (nbr_q == 2'd3) begin
					state_d = ST_TABLE;
				end
			end
			ST_TABLE: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (take) begin
					lat_we    = 1'b1;
					lat_wdata = cand;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					item_q     <= req;
					bad_q      <= arg_bad;
					res_spin_q <= 4'd0;
					acc_q      <= 1'b0;
					oc_q       <= 3'd0;
					nc_q       <= 3'd0;
					nbr_q      <= 2'd0;
				end
			end
			ST_EXEC: begin
				if (!bad_q && item_q.op == OP_WRITE) begin
					res_spin_q <= item_q.spin_value;
				end
			end
			ST_SITE: begin
				if (item_q.op == OP_READ) begin
					res_spin_q <= lat_rdata;
				end else begin
					olds_q <= lat_rdata;
					if (stale) begin
						bad_q <= 1'b1;
					end
				end
			end
			ST_NBR: begin
				oc_q  <= oc_q + {2'd0, lat_rdata == olds_q};
				nc_q  <= nc_q + {2'd0, lat_rdata == cand};
				nbr_q <= nbr_q + 2'd1;
			end
			ST_DECIDE: begin
				acc_q      <= take;
				res_spin_q <= take ? cand : olds_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.result_spin     = bad_q ? 4'd0 : res_spin_q;
		res.accepted        = bad_q ? 1'b0 : acc_q;
		res.old_match_count = bad_q ? 3'd0 : oc_q;
		res.new_match_count = bad_q ? 3'd0 : nc_q;
		res.status          = bad_q;
	end

	`ASSERT_NEVER(a_one_store_write, clk, arst_n, lat_we && tbl_we, "both stores written at once")
	`ASSERT_IMPL(a_flip_changes_spin, clk, arst_n, (state_q == ST_DECIDE) && lat_we, lat_wdata != olds_q, "flip writes the old spin")
	`ASSERT_IMPL(a_counts_bounded, clk, arst_n, state_q == ST_TABLE, (oc_q <= MATCH_MAX) && (nc_q <= MATCH_MAX), "match count above four")
	`ASSERT_IMPL(a_site_after_exec, clk, arst_n, state_q == ST_SITE, $past(state_q) == ST_EXEC, "site read not issued from exec")

endmodule

`default_nettype wire

@@ rtl/core/potts_metropolis_spin_update_core.sv @@
// ----------------------------------------------------------------------------
// potts_metropolis_spin_update_core
// Flow from input transfer to rsp_valid: load, write and ignored items pass
// EXEC and DONE; a read or a step stopped by a stale spin also passes SITE;
// a Metropolis step passes SITE, NBR, TABLE and DECIDE. The next item is
// taken in the cycle after the result enters the output register.
// The step is paced by the single lattice port: site, four neighbors, then
// the table read and write-back. Reset clears control and configuration only.
// ----------------------------------------------------------------------------
`default_nettype none

module potts_metropolis_spin_update_core import potts_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int MAX_STATES = MAX_STATES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire potts_in_t  req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output potts_out_t      rsp,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int LAT_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int TBL_DEPTH = MAX_STATES * MAX_STATES * TABLE_ROW;
	localparam int LAT_AW    = $clog2(LAT_DEPTH);
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	potts_cfg_t cfg_q;
	logic       rsp_valid_q;
	potts_out_t rsp_q;

	logic              res_valid, res_ready;
	potts_out_t        res;
	logic              lat_we, tbl_we;
	logic [LAT_AW-1:0] lat_addr;
	logic [TBL_AW-1:0] tbl_addr;
	logic [3:0]        lat_wdata, lat_rdata;
	logic [16:0]       tbl_wdata, tbl_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
			cfg_q.states <= STATES_RST;
		end else if (cfg_we) begin
			case (potts_reg_t'(cfg_index))
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_STATES: cfg_q.states <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// output register frees the sequencer while a result waits
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	potts_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_STATES(MAX_STATES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.lat_we   (lat_we),
		.lat_addr (lat_addr),
		.lat_wdata(lat_wdata),
		.lat_rdata(lat_rdata),
		.tbl_we   (tbl_we),
		.tbl_addr (tbl_addr),
		.tbl_wdata(tbl_wdata),
		.tbl_rdata(tbl_rdata)
	);

	potts_ram #(
		.WIDTH(4),
		.DEPTH(LAT_DEPTH)
	) u_lattice (
		.clk  (clk),
		.we   (lat_we),
		.addr (lat_addr),
		.wdata(lat_wdata),
		.rdata(lat_rdata)
	);

	potts_ram #(
		.WIDTH(17),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.addr (tbl_addr),
		.wdata(tbl_wdata),
		.rdata(tbl_rdata)
	);

endmodule

`default_nettype wire

@@ tb/tb_potts_metropolis_spin_update_core.sv @@
// ----------------------------------------------------------------------------
// tb_potts_metropolis_spin_update_core
// Self-checking bench for the Potts Metropolis spin update core. A mirror of
// the lattice and acceptance table predicts every response. Table loads,
// spin writes, reads and steps are driven over several lattice sizes and state
// counts, with random idle and stall on both channels. Before a step or a read
// touches a site or table entry not yet written, the bench writes it first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_potts_metropolis_spin_update_core;
	import potts_pkg::*;

	localparam int QUIET_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int ITEMS_PER_PHASE = 32;

	// Mirror of the core: configuration, lattice and table contents, plus the
	// responses still owed by the core, oldest first.
	class spin_update_mirror;
		logic [7:0]  width_reg;
		logic [7:0]  height_reg;
		logic [4:0]  states_reg;
		logic [3:0]  spins    [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
		bit          site_set [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
		logic [16:0] probs    [MAX_STATES_DEF * MAX_STATES_DEF * TABLE_ROW];
		bit          prob_set [MAX_STATES_DEF * MAX_STATES_DEF * TABLE_ROW];
		potts_out_t  pending_spin_results [$];
		int          items_in;
		int          steps;
		int          flips;
		int          ignored;
		int          mismatches;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			states_reg = STATES_RST;
		endfunction

		function void write_reg(potts_reg_t idx, logic [7:0] val);
			case (idx)
				REG_WIDTH:  width_reg = val;
				REG_HEIGHT: height_reg = val;
				REG_STATES: states_reg = val[4:0];
				default: ;
			endcase
		endfunction

		function bit cfg_ok();
			return width_reg >= 2 && width_reg <= MAX_WIDTH_DEF &&
				height_reg >= 2 && height_reg <= MAX_HEIGHT_DEF &&
				states_reg >= 2 && states_reg <= MAX_STATES_DEF;
		endfunction

		function bit in_lattice(potts_in_t it);
			return it.site_x < width_reg && it.site_y < height_reg;
		endfunction

		function int site_of(int x, int y);
			return y * MAX_WIDTH_DEF + x;
		endfunction

		function bit site_known(int x, int y);
			return site_set[site_of(x, y)];
		endfunction

		function int entry_of(logic [3:0] olds, logic [3:0] cand, logic [2:0] oc,
				logic [2:0] nc);
			return ((olds * MAX_STATES_DEF + cand) * MATCH_SPAN + oc) * MATCH_SPAN + nc;
		endfunction

		// torus neighbors: left, up, right, down
		function void neighbor(int x, int y, int k, output int nx, output int ny);
			int w;
			int h;
			w  = width_reg;
			h  = height_reg;
			nx = x;
			ny = y;
			case (k)
				0: nx = (x == 0) ? w - 1 : x - 1;
				1: ny = (y == 0) ? h - 1 : y - 1;
				2: nx = (x + 1 == w) ? 0 : x + 1;
				default: ny = (y + 1 == h) ? 0 : y + 1;
			endcase
		endfunction

		// 1 when a step on this site reads the table; returns the entry key
		function bit table_key(potts_in_t it, output logic [3:0] olds,
				output logic [3:0] cand, output logic [2:0] oc, output logic [2:0] nc);
			int nx;
			int ny;
			int k;
			logic [3:0] nb;
			olds = spins[site_of(it.site_x, it.site_y)];
			cand = '0;
			oc   = '0;
			nc   = '0;
			if (it.candidate_offset >= states_reg - 1 || olds >= states_reg)
				return 1'b0;
			// skip over the current spin
			cand = (it.candidate_offset < olds) ? it.candidate_offset :
				it.candidate_offset + 4'd1;
			for (k = 0; k < 4; k++) begin
				neighbor(it.site_x, it.site_y, k, nx, ny);
				nb = spins[site_of(nx, ny)];
				oc += (nb == olds);
				nc += (nb == cand);
			end
			return 1'b1;
		endfunction

		function potts_out_t predict_result(potts_in_t it);
			potts_out_t r;
			bit bad;
			int site;
			int e;
			logic [3:0] olds;
			logic [3:0] cand;
			logic [2:0] oc;
			logic [2:0] nc;
			r    = '0;
			bad  = !cfg_ok();
			site = site_of(it.site_x, it.site_y);
			if (!bad && it.op != OP_LOAD && !in_lattice(it))
				bad = 1'b1;
			if (!bad) begin
				case (it.op)
					OP_LOAD: begin
						if (it.spin_value >= states_reg || it.other_spin >= states_reg ||
								it.old_matches > MATCH_MAX || it.new_matches > MATCH_MAX ||
								it.probability > PROB_ONE) begin
							bad = 1'b1;
						end else begin
							e = entry_of(it.spin_value, it.other_spin, it.old_matches,
								it.new_matches);
							probs[e]    = it.probability;
							prob_set[e] = 1'b1;
						end
					end
					OP_WRITE: begin
						if (it.spin_value >= states_reg) begin
							bad = 1'b1;
						end else begin
							spins[site]    = it.spin_value;
							site_set[site] = 1'b1;
							r.result_spin  = it.spin_value;
						end
					end
					OP_READ: r.result_spin = spins[site];
					default: begin
						if (!table_key(it, olds, cand, oc, nc)) begin
							bad = 1'b1;
						end else begin
							steps++;
							r.old_match_count = oc;
							r.new_match_count = nc;
							if ({1'b0, it.random_draw} <= probs[entry_of(olds, cand, oc, nc)]) begin
								spins[site]   = cand;
								r.accepted    = 1'b1;
								r.result_spin = cand;
								flips++;
							end else begin
								r.result_spin = olds;
							end
						end
					end
				endcase
			end
			if (bad) begin
				r        = '0;
				r.status = 1'b1;
				ignored++;
			end
			return r;
		endfunction

		function void note_transfer(potts_in_t it);
			items_in++;
			pending_spin_results.push_back(predict_result(it));
		endfunction

		function void check_field(string name, int want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_rsp(potts_out_t got);
			potts_out_t want;
			if (pending_spin_results.size() == 0) begin
				$error("response with no request outstanding: result_spin %0d status %0d",
					got.result_spin, got.status);
				mismatches++;
				return;
			end
			want = pending_spin_results.pop_front();
			check_field("result_spin", want.result_spin, got.result_spin);
			check_field("accepted", want.accepted, got.accepted);
			check_field("old_match_count", want.old_match_count, got.old_match_count);
			check_field("new_match_count", want.new_match_count, got.new_match_count);
			check_field("status", want.status, got.status);
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	potts_in_t  req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	potts_out_t rsp;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = REG_WIDTH;
	logic [7:0] cfg_data  = '0;

	spin_update_mirror mirror;
	int send_idle_pct = 16;
	int rcv_stall_pct = 87;
	int config_count  = 0;

	potts_metropolis_spin_update_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_rsp(rsp);
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic potts_in_t random_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(potts_in_t)-1:0];
	endfunction

	function automatic potts_in_t item_of(potts_op_t op, int x, int y, int sv,
			int off = 0, int draw = 0);
		potts_in_t it;
		it                  = random_item();
		it.op               = op;
		it.site_x           = 7'(x);
		it.site_y           = 7'(y);
		it.spin_value       = 4'(sv);
		it.candidate_offset = 4'(off);
		it.random_draw      = 16'(draw);
		return it;
	endfunction

	function automatic logic [16:0] pick_prob();
		case ($urandom_range(3))
			0: return '0;
			1: return PROB_ONE;
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// edges, any site and a small corner patch, so sites get reused
	function automatic logic [6:0] pick_coord(int n);
		case ($urandom_range(3))
			0: return '0;
			1: return 7'(n - 1);
			2: return 7'($urandom_range(n - 1));
			default: return 7'($urandom_range(((n < 6) ? n : 6) - 1));
		endcase
	endfunction

	// called just after the clock rises; returns once the core has taken the item
	task automatic send_item(potts_in_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		mirror.note_transfer(it);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (mirror.pending_spin_results.size() != 0);
	endtask

	task automatic write_reg(potts_reg_t idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		mirror.write_reg(idx, val);
	endtask

	task automatic set_config(logic [7:0] w, logic [7:0] h, logic [4:0] q);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		// upper bits of the state count register are don't-care
		write_reg(REG_STATES, {3'($urandom), q});
		cfg_we <= 1'b0;
		config_count++;
	endtask

	task automatic send_write(int x, int y, int sv);
		send_item(item_of(OP_WRITE, x, y, sv));
	endtask

	task automatic send_load(int olds, int cand, int om, int nm, int prob);
		potts_in_t it;
		it             = random_item();
		it.op          = OP_LOAD;
		it.spin_value  = 4'(olds);
		it.other_spin  = 4'(cand);
		it.old_matches = 3'(om);
		it.new_matches = 3'(nm);
		it.probability = 17'(prob);
		send_item(it);
	endtask

	// Writes any unwritten site or table entry the item would read before it is sent.
	// A non-negative load_prob forces a fresh table load for a step.
	task automatic deliver(potts_in_t it, int load_prob = -1);
		logic [3:0] olds;
		logic [3:0] cand;
		logic [2:0] oc;
		logic [2:0] nc;
		int nx;
		int ny;
		int k;
		if ((it.op == OP_READ || it.op == OP_STEP) && mirror.cfg_ok() &&
				mirror.in_lattice(it)) begin
			if (!mirror.site_known(it.site_x, it.site_y))
				send_write(it.site_x, it.site_y, $urandom_range(mirror.states_reg - 1));
			if (it.op == OP_STEP) begin
				for (k = 0; k < 4; k++) begin
					mirror.neighbor(it.site_x, it.site_y, k, nx, ny);
					if (!mirror.site_known(nx, ny))
						send_write(nx, ny, $urandom_range(mirror.states_reg - 1));
				end
				if (mirror.table_key(it, olds, cand, oc, nc) && (load_prob >= 0 ||
						!mirror.prob_set[mirror.entry_of(olds, cand, oc, nc)]))
					send_load(olds, cand, oc, nc, (load_prob >= 0) ? load_prob : pick_prob());
			end
		end
		send_item(it);
	endtask

	// mostly well-formed traffic with random content, the rest raw noise
	task automatic issue_random_op();
		potts_in_t it;
		int q;
		int r;
		it = random_item();
		q  = mirror.states_reg;
		r  = $urandom_range(99);
		if (r < 90) begin
			it.site_x = pick_coord(mirror.width_reg);
			it.site_y = pick_coord(mirror.height_reg);
		end
		if (r < 55) begin
			it.op = OP_STEP;
			if ($urandom_range(9) != 0)
				it.candidate_offset = 4'($urandom_range(q - 2));
			case ($urandom_range(9))
				0, 1: it.random_draw = '0;
				2: it.random_draw = '1;
				default: ;
			endcase
		end else if (r < 70) begin
			it.op = OP_WRITE;
			if ($urandom_range(9) != 0)
				it.spin_value = 4'($urandom_range(q - 1));
		end else if (r < 80) begin
			it.op = OP_READ;
		end else if (r < 90) begin
			it.op = OP_LOAD;
			if ($urandom_range(6) != 0) begin
				it.spin_value  = 4'($urandom_range(q - 1));
				it.other_spin  = 4'($urandom_range(q - 1));
				it.old_matches = 3'($urandom_range(MATCH_MAX));
				it.new_matches = 3'($urandom_range(MATCH_MAX));
				it.probability = pick_prob();
			end
		end
		deliver(it);
		if ($urandom_range(49) == 0)
			drain_results();
	endtask

	initial begin : stimulus
		int phase_w [12] = '{4, 2, 128, 2, 5, 128, 3, 16, 2, 9, 128, 6};
		int phase_h [12] = '{4, 2, 2, 128, 7, 128, 3, 8, 3, 2, 128, 6};
		int phase_q [12] = '{3, 2, 16, 5, 16, 16, 4, 8, 16, 2, 2, 7};
		int bad_w [8] = '{1, 129, 255, 4, 4, 4, 4, 0};
		int bad_h [8] = '{4, 4, 4, 0, 255, 4, 4, 4};
		int bad_q [8] = '{4, 4, 4, 4, 4, 1, 17, 31};
		int p;
		mirror = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 128 x 128, two states
		deliver(item_of(OP_WRITE, 0, 0, 1));
		deliver(item_of(OP_WRITE, 127, 0, 0));
		deliver(item_of(OP_WRITE, 1, 0, 1));
		deliver(item_of(OP_WRITE, 0, 127, 1));
		deliver(item_of(OP_WRITE, 0, 1, 0));
		deliver(item_of(OP_READ, 0, 0, 0));
		deliver(item_of(OP_WRITE, 127, 127, 1));
		deliver(item_of(OP_WRITE, 5, 5, 15));
		// probability one against the largest draw, then zero against zero
		deliver(item_of(OP_STEP, 0, 0, 0, 0, 16'hFFFF), PROB_ONE);
		deliver(item_of(OP_STEP, 0, 0, 0, 0, 0), 0);
		// wraps right and down; draw above probability
		deliver(item_of(OP_STEP, 127, 127, 0, 0, 1), 0);
		deliver(item_of(OP_STEP, 0, 0, 0, 1, 0));
		deliver(item_of(OP_STEP, 0, 0, 0, 15, 0));
		send_load(2, 0, 0, 0, 1);
		send_load(0, 15, 0, 0, 1);
		send_load(0, 1, 5, 0, 1);
		send_load(0, 1, 0, 7, 1);
		send_load(0, 1, 4, 4, 65537);
		send_load(1, 0, 4, 4, 131071);
		send_load(1, 1, 4, 4, 12345);
		send_load(0, 1, 4, 4, PROB_ONE);
		deliver(item_of(OP_READ, 127, 127, 0));

		// small torus: largest offset, coordinates out of range, stale spin
		set_config(3, 2, 16);
		deliver(item_of(OP_STEP, 2, 1, 0, 14, 16'h8000));
		deliver(item_of(OP_WRITE, 1, 1, 15));
		deliver(item_of(OP_STEP, 3, 0, 0, 0, 0));
		deliver(item_of(OP_READ, 0, 2, 0));
		deliver(item_of(OP_WRITE, 127, 127, 3));
		set_config(3, 2, 4);
		deliver(item_of(OP_STEP, 1, 1, 0, 0, 0));

		// invalid settings: every transfer is ignored
		for (p = 0; p < 8; p++) begin
			set_config(8'(bad_w[p]), 8'(bad_h[p]), 5'(bad_q[p]));
			deliver(random_item());
		end

		for (p = 0; p < 12; p++) begin
			case (p / 4)
				0: begin
					send_idle_pct = 16;
					rcv_stall_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					rcv_stall_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			set_config(8'(phase_w[p]), 8'(phase_h[p]), 5'(phase_q[p]));
			repeat (ITEMS_PER_PHASE) issue_random_op();
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("Summary: %0d requests under %0d register settings (sizes 2..128, Q 2..16).",
			mirror.items_in, config_count);
		$display("Summary: %0d Metropolis steps, %0d flips, %0d requests rejected.",
			mirror.steps, mirror.flips, mirror.ignored);
		if (mirror.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
